@@ hw/rtl/srs_pkg.sv @@
// Package for the shortest-remaining-time scheduler: task record, queue operation,
// event codes and sequencer states. Depends on nothing.
`timescale 1ns / 1ps
package srs_pkg;
    localparam int LEN_BITS = 16;
    localparam int QUEUE_DEPTH_DEF = 16;

    typedef struct packed {
        logic [15:0]         id;
        logic [LEN_BITS-1:0] rem;
        logic [15:0]         win;
    } entry_t;

    typedef struct packed {
        logic   push;
        logic   pop;
        entry_t ent;
    } chain_op_t;

    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_FINISH = 2'd1,
        EV_PREEMPT = 2'd2,
        EV_REJECT = 2'd3
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ARR,
        ST_PICK,
        ST_STEP,
        ST_FIN,
        ST_OUT
    } state_t;

    function automatic logic key_lt(input entry_t a, input entry_t b);
        key_lt = (a.rem < b.rem) || ((a.rem == b.rem) && (a.id < b.id));
    endfunction
endpackage

@@ hw/rtl/srs_cell.sv @@
// One cell of the sorted waiting queue; holds a single task record.
// Depends on srs_pkg.
`timescale 1ns / 1ps
module srs_cell
    import srs_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  chain_op_t op,
    input  entry_t    left_ent,
    input  logic      left_valid,
    input  logic      left_lt,
    input  entry_t    right_ent,
    input  logic      right_valid,
    output entry_t    ent,
    output logic      valid,
    output logic      lt
);
    entry_t ent_reg, ent_next;
    logic   valid_reg, valid_next;
    logic   less_self;

    assign less_self = !valid_reg || key_lt(op.ent, ent_reg);
    assign lt = valid_reg && key_lt(op.ent, ent_reg);

    always_comb
    begin
        ent_next = ent_reg;
        valid_next = valid_reg;
        if (op.pop)
        begin
            ent_next = right_ent;
            valid_next = right_valid;
        end
        else if (op.push)
        begin
            if (left_lt)
            begin
                ent_next = left_ent;
                valid_next = left_valid;
            end
            else if (less_self && left_valid)
            begin
                ent_next = op.ent;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

    assign ent = ent_reg;
    assign valid = valid_reg;
endmodule

@@ hw/rtl/preemptive_shortest_remaining_scheduler_unit.sv @@
// Top level of the shortest-remaining-time scheduler: sequencer, running task and
// counters around a sorted chain of queue cells. Depends on srs_pkg and srs_cell.
//
//   channel | signals                                         | role
//   in      | in_valid in_ready mode arrival_*                | one scheduler item
//   out     | out_valid out_ready event_res task_id ...       | one result per item
//
// An item passes through acceptance, arrival, optional pick, a time step on a tick
// that does not preempt, optional pick after a finish, and the output load.
// Each queue insert or removal shifts the chain of cells. Reset empties the queue at
// once. A stalled result holds the sequencer in its output step.
`timescale 1ns / 1ps
module preemptive_shortest_remaining_scheduler_unit
    import srs_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        mode,
    input  logic        arrival_valid,
    input  logic [15:0] arrival_length,
    input  logic [15:0] arrival_window,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  event_res,
    output logic [15:0] task_id,
    output logic [15:0] preemptor_id,
    output logic [31:0] event_time,
    output logic [39:0] finish_sum,
    output logic [15:0] finished_count,
    output logic        busy_res
);
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_BITS-1:0] DEPTH_C = CNT_BITS'(QUEUE_DEPTH);
    localparam logic [31:0] LEN_MAX = 32'((64'd1 << LEN_BITS) - 64'd1);
    localparam logic [39:0] SUM_MAX = {40{1'b1}};

    state_t              state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                run_v_reg, run_v_next;
    entry_t              run_reg, run_next;
    logic [15:0]         tick_reg, tick_next;
    logic [31:0]         time_reg, time_next;
    logic [39:0]         sum_reg, sum_next;
    logic [15:0]         nid_reg, nid_next;
    logic [15:0]         done_reg, done_next;
    logic                mode_reg, mode_next;
    logic                av_reg, av_next;
    entry_t              nj_reg, nj_next;
    event_t              ev_reg, ev_next;
    logic [15:0]         tid_reg, tid_next;
    logic [15:0]         pid_reg, pid_next;
    logic                ov_reg, ov_next;
    logic [1:0]          o_ev_reg, o_ev_next;
    logic [15:0]         o_tid_reg, o_tid_next;
    logic [15:0]         o_pid_reg, o_pid_next;
    logic [31:0]         o_time_reg, o_time_next;
    logic [39:0]         o_sum_reg, o_sum_next;
    logic [15:0]         o_done_reg, o_done_next;
    logic                o_busy_reg, o_busy_next;

    chain_op_t op;
    entry_t    ent_w   [QUEUE_DEPTH];
    logic      valid_w [QUEUE_DEPTH];
    logic      lt_w    [QUEUE_DEPTH];
    entry_t    zero_ent;
    logic [31:0] len_ext;
    logic [LEN_BITS-1:0] rem_dec;
    logic [40:0] sum_add;
    logic [15:0] nid_inc;

    assign zero_ent = '0;

    genvar gi;
    generate
        for (gi = 0; gi < QUEUE_DEPTH; gi++)
        begin : g_cell
            entry_t l_ent, r_ent;
            logic   l_valid, l_lt, r_valid;
            if (gi == 0)
            begin : g_first
                assign l_ent = zero_ent;
                assign l_valid = 1'b1;
                assign l_lt = 1'b0;
            end
            else
            begin : g_mid
                assign l_ent = ent_w[gi-1];
                assign l_valid = valid_w[gi-1];
                assign l_lt = lt_w[gi-1];
            end
            if (gi == QUEUE_DEPTH - 1)
            begin : g_last
                assign r_ent = zero_ent;
                assign r_valid = 1'b0;
            end
            else
            begin : g_inner
                assign r_ent = ent_w[gi+1];
                assign r_valid = valid_w[gi+1];
            end
            srs_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .op          (op),
                .left_ent    (l_ent),
                .left_valid  (l_valid),
                .left_lt     (l_lt),
                .right_ent   (r_ent),
                .right_valid (r_valid),
                .ent         (ent_w[gi]),
                .valid       (valid_w[gi]),
                .lt          (lt_w[gi])
            );
        end
    endgenerate

    assign in_ready = (state_reg == ST_IDLE);
    assign len_ext = {16'd0, arrival_length};
    assign rem_dec = run_reg.rem - LEN_BITS'(1);
    assign sum_add = {1'b0, sum_reg} + {9'd0, time_reg + 32'd1};
    assign nid_inc = nid_reg + 16'd1;

    always_comb
    begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        run_v_next = run_v_reg;
        run_next = run_reg;
        tick_next = tick_reg;
        time_next = time_reg;
        sum_next = sum_reg;
        nid_next = nid_reg;
        done_next = done_reg;
        mode_next = mode_reg;
        av_next = av_reg;
        nj_next = nj_reg;
        ev_next = ev_reg;
        tid_next = tid_reg;
        pid_next = pid_reg;
        ov_next = ov_reg;
        o_ev_next = o_ev_reg;
        o_tid_next = o_tid_reg;
        o_pid_next = o_pid_reg;
        o_time_next = o_time_reg;
        o_sum_next = o_sum_reg;
        o_done_next = o_done_reg;
        o_busy_next = o_busy_reg;
        op.push = 1'b0;
        op.pop = 1'b0;
        op.ent = nj_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    mode_next = mode;
                    av_next = arrival_valid;
                    nj_next.id = nid_reg;
                    nj_next.win = arrival_window;
                    if (arrival_length == 16'd0)
                    begin
                        nj_next.rem = LEN_BITS'(1);
                    end
                    else if (len_ext > LEN_MAX)
                    begin
                        nj_next.rem = LEN_MAX[LEN_BITS-1:0];
                    end
                    else
                    begin
                        nj_next.rem = LEN_BITS'(len_ext);
                    end
                    if (arrival_valid)
                    begin
                        nid_next = (nid_inc == 16'd0) ? 16'd1 : nid_inc;
                    end
                    state_next = ST_ARR;
                end
            end
            ST_ARR:
            begin
                ev_next = EV_NONE;
                tid_next = av_reg ? nj_reg.id : 16'd0;
                pid_next = 16'd0;
                state_next = (mode_reg && !run_v_reg) ? ST_PICK :
                             (mode_reg ? ST_STEP : ST_OUT);
                if (av_reg)
                begin
                    if (mode_reg && run_v_reg && (cnt_reg < DEPTH_C) &&
                        (tick_reg < run_reg.win) && (nj_reg.rem < run_reg.rem))
                    begin
                        ev_next = EV_PREEMPT;
                        tid_next = run_reg.id;
                        pid_next = nj_reg.id;
                        op.push = 1'b1;
                        op.ent = run_reg;
                        cnt_next = cnt_reg + CNT_BITS'(1);
                        run_next = nj_reg;
                        tick_next = 16'd0;
                        state_next = ST_OUT;
                    end
                    else if (cnt_reg >= DEPTH_C)
                    begin
                        ev_next = EV_REJECT;
                    end
                    else
                    begin
                        op.push = 1'b1;
                        cnt_next = cnt_reg + CNT_BITS'(1);
                    end
                end
            end
            ST_PICK, ST_FIN:
            begin
                if (cnt_reg != '0)
                begin
                    run_next = ent_w[0];
                    run_v_next = 1'b1;
                    tick_next = 16'd0;
                    op.pop = 1'b1;
                    cnt_next = cnt_reg - CNT_BITS'(1);
                end
                state_next = (state_reg == ST_PICK) ? ST_STEP : ST_OUT;
            end
            ST_STEP:
            begin
                state_next = ST_OUT;
                if (run_v_reg)
                begin
                    time_next = time_reg + 32'd1;
                    run_next.rem = rem_dec;
                    if (tick_reg != 16'hFFFF)
                    begin
                        tick_next = tick_reg + 16'd1;
                    end
                    if (rem_dec == '0)
                    begin
                        sum_next = (sum_add > {1'b0, SUM_MAX}) ? SUM_MAX : sum_add[39:0];
                        done_next = done_reg + 16'd1;
                        run_v_next = 1'b0;
                        if (ev_reg != EV_REJECT)
                        begin
                            ev_next = EV_FINISH;
                            tid_next = run_reg.id;
                        end
                        state_next = ST_FIN;
                    end
                end
            end
            ST_OUT:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next = 1'b1;
                    o_ev_next = ev_reg;
                    o_tid_next = tid_reg;
                    o_pid_next = pid_reg;
                    o_time_next = time_reg;
                    o_sum_next = sum_reg;
                    o_done_next = done_reg;
                    o_busy_next = run_v_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            run_v_reg <= 1'b0;
            run_reg <= '0;
            tick_reg <= 16'd0;
            time_reg <= 32'd0;
            sum_reg <= 40'd0;
            nid_reg <= 16'd1;
            done_reg <= 16'd0;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            run_v_reg <= run_v_next;
            run_reg <= run_next;
            tick_reg <= tick_next;
            time_reg <= time_next;
            sum_reg <= sum_next;
            nid_reg <= nid_next;
            done_reg <= done_next;
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg <= mode_next;
        av_reg <= av_next;
        nj_reg <= nj_next;
        ev_reg <= ev_next;
        tid_reg <= tid_next;
        pid_reg <= pid_next;
        o_ev_reg <= o_ev_next;
        o_tid_reg <= o_tid_next;
        o_pid_reg <= o_pid_next;
        o_time_reg <= o_time_next;
        o_sum_reg <= o_sum_next;
        o_done_reg <= o_done_next;
        o_busy_reg <= o_busy_next;
    end

    assign out_valid = ov_reg;
    assign event_res = o_ev_reg;
    assign task_id = o_tid_reg;
    assign preemptor_id = o_pid_reg;
    assign event_time = o_time_reg;
    assign finish_sum = o_sum_reg;
    assign finished_count = o_done_reg;
    assign busy_res = o_busy_reg;

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C)
        else $error("Queue count exceeds its depth.");
    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        valid_w[0] == (cnt_reg != '0))
        else $error("Queue head does not match the count.");
    a_run_rem: assert property (@(posedge clk) disable iff (!rst_n)
        run_v_reg |-> (run_reg.rem != '0))
        else $error("Running task has no remaining time.");
    a_accept_arr: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_ARR))
        else $error("Accepted transfer did not start the arrival step.");
endmodule

@@ tb/sv/tb.sv @@
// Testbench for the shortest-remaining-time scheduler: directed and random task streams
// checked against an in-bench scheduler model. Depends on srs_pkg and the scheduler top.
`timescale 1ns / 1ps
module tb;
    import srs_pkg::*;

    localparam int DEPTH = 16;

    typedef struct {
        event_t      ev;
        logic [15:0] tid;
        logic [15:0] pid;
        logic [31:0] tnow;
        logic [39:0] fsum;
        logic [15:0] fcount;
        logic        busy;
    } sched_result_t;

    typedef struct {
        logic [15:0] id;
        logic [15:0] rem;
        logic [15:0] win;
    } job_rec_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic        mode = 1'b0;
    logic        arrival_valid = 1'b0;
    logic [15:0] arrival_length = 16'd0;
    logic [15:0] arrival_window = 16'd0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  event_res;
    logic [15:0] task_id;
    logic [15:0] preemptor_id;
    logic [31:0] event_time;
    logic [39:0] finish_sum;
    logic [15:0] finished_count;
    logic        busy_res;

    sched_result_t pending_results[$];
    int          failures = 0;

    job_rec_t    queue_m[DEPTH];
    int          qcount;
    logic        run_v;
    job_rec_t    run_t;
    logic [15:0] since_pick;
    logic [31:0] now_m;
    logic [40:0] sum_m;
    logic [15:0] nid_m;
    logic [15:0] done_m;

    preemptive_shortest_remaining_scheduler_unit uut (.*);

    always #5 clk = ~clk;

    function automatic void pick_shortest_job();
        int best;
        best = 0;
        if (qcount == 0)
            return;
        for (int k = 1; k < qcount; k++)
            if (queue_m[k].rem < queue_m[best].rem ||
                (queue_m[k].rem == queue_m[best].rem && queue_m[k].id < queue_m[best].id))
                best = k;
        run_t = queue_m[best];
        run_v = 1'b1;
        since_pick = 16'd0;
        qcount--;
        queue_m[best] = queue_m[qcount];
    endfunction

    function automatic sched_result_t schedule_item(logic md, logic av, logic [15:0] len,
                                                    logic [15:0] win);
        sched_result_t r;
        job_rec_t      nj;
        logic          pre;
        logic [15:0]   fid;
        r.ev = EV_NONE;
        r.tid = 16'd0;
        r.pid = 16'd0;
        pre = 1'b0;
        if (av) begin
            nj.id = nid_m;
            nid_m = nid_m + 16'd1;
            if (nid_m == 16'd0)
                nid_m = 16'd1;
            nj.rem = (len == 16'd0) ? 16'd1 : len;
            nj.win = win;
            r.tid = nj.id;
            if (md && run_v && qcount < DEPTH && since_pick < run_t.win && nj.rem < run_t.rem)
            begin
                r.ev = EV_PREEMPT;
                r.tid = run_t.id;
                r.pid = nj.id;
                queue_m[qcount] = run_t;
                qcount++;
                run_t = nj;
                since_pick = 16'd0;
                pre = 1'b1;
            end
            else if (qcount >= DEPTH)
                r.ev = EV_REJECT;
            else
            begin
                queue_m[qcount] = nj;
                qcount++;
            end
        end
        if (md && !pre) begin
            if (!run_v)
                pick_shortest_job();
            if (run_v) begin
                now_m = now_m + 32'd1;
                run_t.rem = run_t.rem - 16'd1;
                if (since_pick != 16'hFFFF)
                    since_pick = since_pick + 16'd1;
                if (run_t.rem == 16'd0) begin
                    fid = run_t.id;
                    sum_m = sum_m + now_m;
                    if (sum_m > 41'hFF_FFFF_FFFF)
                        sum_m = 41'hFF_FFFF_FFFF;
                    done_m = done_m + 16'd1;
                    run_v = 1'b0;
                    pick_shortest_job();
                    if (r.ev != EV_REJECT) begin
                        r.ev = EV_FINISH;
                        r.tid = fid;
                    end
                end
            end
        end
        r.tnow = now_m;
        r.fsum = sum_m[39:0];
        r.fcount = done_m;
        r.busy = run_v;
        return r;
    endfunction

    task automatic send_item(logic md, logic av, logic [15:0] len, logic [15:0] win);
        int gap;
        gap = $urandom_range(0, 5);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        mode <= md;
        arrival_valid <= av;
        arrival_length <= len;
        arrival_window <= win;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_results.push_back(schedule_item(md, av, len, win));
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    always @(posedge clk) begin
        sched_result_t e;
        if (out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                failures++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (event_res != e.ev) begin
                    $error("event_res exp %0d got %0d", e.ev, event_res); failures++;
                end
                if (task_id != e.tid) begin
                    $error("task_id exp %0d got %0d", e.tid, task_id); failures++;
                end
                if (preemptor_id != e.pid) begin
                    $error("preemptor_id exp %0d got %0d", e.pid, preemptor_id); failures++;
                end
                if (event_time != e.tnow) begin
                    $error("event_time exp %0d got %0d", e.tnow, event_time); failures++;
                end
                if (finish_sum != e.fsum) begin
                    $error("finish_sum exp %0d got %0d", e.fsum, finish_sum); failures++;
                end
                if (finished_count != e.fcount) begin
                    $error("finished_count exp %0d got %0d", e.fcount, finished_count);
                    failures++;
                end
                if (busy_res != e.busy) begin
                    $error("busy_res exp %0d got %0d", e.busy, busy_res); failures++;
                end
            end
        end
    end

    initial begin
        int hold;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (out_valid && out_ready)
            begin
                hold = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                out_ready <= (hold == 0);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_item(1'b1, 1'b0, 16'd0, 16'd0);
        send_item(1'b0, 1'b1, 16'd0, 16'd0);
        send_item(1'b0, 1'b1, 16'hFFFF, 16'hFFFF);
        send_item(1'b1, 1'b1, 16'd3, 16'hFFFF);
        send_item(1'b1, 1'b1, 16'd1, 16'd5);
        for (int i = 0; i < 3; i++)
            send_item(1'b1, 1'b0, 16'd0, 16'd0);
        for (int i = 0; i < 16; i++)
            send_item(1'b0, 1'b1, 16'(i + 2), 16'hAAAA);
        send_item(1'b1, 1'b1, 16'd1, 16'h5555);
        drain_results();
    endtask

    task automatic test_random_tasks();
        logic [15:0] len;
        for (int i = 0; i < 1000; i++) begin
            case ($urandom_range(0, 9))
                0: len = 16'($urandom);
                1: len = 16'hFFFF;
                2: len = 16'd0;
                default: len = 16'($urandom_range(1, 12));
            endcase
            send_item(($urandom_range(0, 3) != 0), ($urandom_range(0, 2) == 0), len,
                      ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6)));
            if (i == 500)
                drain_results();
        end
    endtask

    task automatic test_run_out();
        for (int i = 0; i < 120; i++)
            send_item(1'b1, ($urandom_range(0, 9) == 0), 16'($urandom_range(0, 3)),
                      16'($urandom_range(0, 3)));
    endtask

    initial begin
        qcount = 0;
        run_v = 1'b0;
        since_pick = 16'd0;
        now_m = 32'd0;
        sum_m = 41'd0;
        nid_m = 16'd1;
        done_m = 16'd0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random_tasks();
        test_run_out();
        drain_results();
        if (failures == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

    initial begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end
endmodule
